@@ design/prbm_pkg.sv @@
package prbm_pkg;

    localparam int PAGE_W = 16;
    localparam int SLOT_W = 3;
    localparam int CNT_W  = 32;

    typedef enum logic [1:0] {
        POL_LRU   = 2'd0,
        POL_FIFO  = 2'd1,
        POL_CLOCK = 2'd2,
        POL_MRU   = 2'd3
    } policy_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_SWEEP,
        ST_EVICT
    } state_t;

    typedef struct packed {
        logic capture;
        logic resolve;
        logic sweep;
        logic evict;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic exists;
        logic full;
        logic clock_mode;
        logic hand_ref;
    } status_t;

endpackage

@@ design/prbm_if.sv @@
interface prbm_req_if;
    logic                        valid;
    logic                        ready;
    logic [prbm_pkg::PAGE_W-1:0] page_id;
    logic                        page_exists;
    logic                        dirty_mark;

    modport source (output valid, page_id, page_exists, dirty_mark, input ready);
    modport sink   (input valid, page_id, page_exists, dirty_mark, output ready);
endinterface

interface prbm_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        hit;
    logic                        loaded;
    logic [prbm_pkg::SLOT_W-1:0] slot;
    logic                        evicted;
    logic [prbm_pkg::PAGE_W-1:0] victim_page;
    logic                        victim_dirty;
    logic [prbm_pkg::CNT_W-1:0]  hits_so_far;
    logic [prbm_pkg::CNT_W-1:0]  misses_so_far;

    modport source (output valid, hit, loaded, slot, evicted, victim_page, victim_dirty,
                    hits_so_far, misses_so_far, input ready);
    modport sink   (input valid, hit, loaded, slot, evicted, victim_page, victim_dirty,
                    hits_so_far, misses_so_far, output ready);
endinterface

interface prbm_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] policy;

    modport source (output valid, policy, input ready);
    modport sink   (input valid, policy, output ready);
endinterface

@@ design/prbm_ctrl.sv @@
module prbm_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  prbm_pkg::status_t st,
    output prbm_pkg::cmd_t    cmd
);

    prbm_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;
    logic             out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= prbm_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_load   = 1'b0;
        out_free   = !out_valid_reg || out_ready;
        case (state_reg)
            prbm_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = prbm_pkg::ST_LOOK;
                end
            end
            prbm_pkg::ST_LOOK:
            begin
                if (out_free)
                begin
                    cmd.resolve = 1'b1;
                    if (st.hit || !st.exists || !st.full)
                    begin
                        out_load   = 1'b1;
                        state_next = prbm_pkg::ST_IDLE;
                    end
                    else if (st.clock_mode)
                        state_next = prbm_pkg::ST_SWEEP;
                    else
                        state_next = prbm_pkg::ST_EVICT;
                end
            end
            prbm_pkg::ST_SWEEP:
            begin
                // clear referenced slots under the hand until a clear one turns up
                cmd.sweep = 1'b1;
                if (!st.hand_ref)
                    state_next = prbm_pkg::ST_EVICT;
            end
            prbm_pkg::ST_EVICT:
            begin
                if (out_free)
                begin
                    cmd.evict  = 1'b1;
                    out_load   = 1'b1;
                    state_next = prbm_pkg::ST_IDLE;
                end
            end
            default:
                state_next = prbm_pkg::ST_IDLE;
        endcase
        out_valid_next = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    assign out_valid = out_valid_reg;

endmodule

@@ design/prbm_dp.sv @@
module prbm_dp
#(
    parameter int ENTRIES      = 8,
    parameter int PAGE_ID_BITS = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  prbm_pkg::cmd_t                    cmd,
    output prbm_pkg::status_t                 st,
    input  logic [prbm_pkg::PAGE_W-1:0]       page_id,
    input  logic                              page_exists,
    input  logic                              dirty_mark,
    input  logic                              cfg_write,
    input  logic [1:0]                        cfg_policy,
    output logic                              hit,
    output logic                              loaded,
    output logic [prbm_pkg::SLOT_W-1:0]       slot,
    output logic                              evicted,
    output logic [prbm_pkg::PAGE_W-1:0]       victim_page,
    output logic                              victim_dirty,
    output logic [prbm_pkg::CNT_W-1:0]        hits_so_far,
    output logic [prbm_pkg::CNT_W-1:0]        misses_so_far
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W = $clog2(ENTRIES + 1);

    prbm_pkg::policy_t policy_reg, policy_next;

    logic [PAGE_ID_BITS-1:0] page_q_reg, page_q_next;
    logic                    exists_q_reg, exists_q_next;
    logic                    dirty_q_reg, dirty_q_next;

    logic [PAGE_ID_BITS-1:0] tag_reg   [ENTRIES];
    logic [PAGE_ID_BITS-1:0] tag_next  [ENTRIES];
    logic                    dty_reg   [ENTRIES];
    logic                    dty_next  [ENTRIES];
    logic [IDX_W-1:0]        rank_reg  [ENTRIES];
    logic [IDX_W-1:0]        rank_next [ENTRIES];
    logic [ENTRIES-1:0]      ref_reg, ref_next;

    logic [OCC_W-1:0]        occ_reg, occ_next;
    logic [IDX_W-1:0]        hand_reg, hand_next;
    logic [IDX_W-1:0]        victim_reg, victim_next;
    logic [prbm_pkg::CNT_W-1:0] hcnt_reg, hcnt_next;
    logic [prbm_pkg::CNT_W-1:0] mcnt_reg, mcnt_next;

    logic                        r_hit_reg, r_hit_next;
    logic                        r_loaded_reg, r_loaded_next;
    logic [IDX_W-1:0]            r_slot_reg, r_slot_next;
    logic                        r_evicted_reg, r_evicted_next;
    logic [PAGE_ID_BITS-1:0]     r_vpage_reg, r_vpage_next;
    logic                        r_vdirty_reg, r_vdirty_next;

    logic [ENTRIES-1:0] match;
    logic               found;
    logic [IDX_W-1:0]   hit_idx;
    logic               full;
    logic               is_clock;
    logic [IDX_W-1:0]   rank_want;
    logic [IDX_W-1:0]   rank_vic;
    logic               rank_vic_ok;
    logic [IDX_W-1:0]   tail;
    logic [IDX_W-1:0]   last_idx;
    logic [IDX_W-1:0]   vrank;
    logic [IDX_W-1:0]   src_rank;

    assign full     = (occ_reg == OCC_W'(ENTRIES));
    assign is_clock = (policy_reg == prbm_pkg::POL_CLOCK);
    assign tail     = occ_reg[IDX_W-1:0];
    assign last_idx = IDX_W'(ENTRIES - 1);

    // tag compare and first match
    always_comb
    begin
        found   = 1'b0;
        hit_idx = '0;
        for (int j = 0; j < ENTRIES; j++)
        begin
            match[j] = (j < int'(occ_reg)) && (tag_reg[j] == page_q_reg);
            if (match[j] && !found)
            begin
                found   = 1'b1;
                hit_idx = IDX_W'(j);
            end
        end
    end

    // recency victim: oldest rank for LRU, newest for MRU
    always_comb
    begin
        rank_want   = (policy_reg == prbm_pkg::POL_MRU) ? '0 : last_idx;
        rank_vic    = '0;
        rank_vic_ok = 1'b0;
        for (int j = 0; j < ENTRIES; j++)
        begin
            if ((rank_reg[j] == rank_want) && !rank_vic_ok)
            begin
                rank_vic_ok = 1'b1;
                rank_vic    = IDX_W'(j);
            end
        end
    end

    always_comb
    begin
        policy_next    = policy_reg;
        page_q_next    = page_q_reg;
        exists_q_next  = exists_q_reg;
        dirty_q_next   = dirty_q_reg;
        tag_next       = tag_reg;
        dty_next       = dty_reg;
        rank_next      = rank_reg;
        ref_next       = ref_reg;
        occ_next       = occ_reg;
        hand_next      = hand_reg;
        victim_next    = victim_reg;
        hcnt_next      = hcnt_reg;
        mcnt_next      = mcnt_reg;
        r_hit_next     = r_hit_reg;
        r_loaded_next  = r_loaded_reg;
        r_slot_next    = r_slot_reg;
        r_evicted_next = r_evicted_reg;
        r_vpage_next   = r_vpage_reg;
        r_vdirty_next  = r_vdirty_reg;
        vrank          = rank_reg[victim_reg];
        src_rank       = '0;

        if (cfg_write)
            policy_next = prbm_pkg::policy_t'(cfg_policy);

        if (cmd.capture)
        begin
            page_q_next   = (PAGE_ID_BITS)'(page_id);
            exists_q_next = page_exists;
            dirty_q_next  = dirty_mark;
        end

        if (cmd.resolve)
        begin
            r_hit_next     = found;
            r_loaded_next  = 1'b0;
            r_slot_next    = '0;
            r_evicted_next = 1'b0;
            r_vpage_next   = '0;
            r_vdirty_next  = 1'b0;
            if (found)
            begin
                r_slot_next = hit_idx;
                if (!(&hcnt_reg))
                    hcnt_next = hcnt_reg + 1'b1;
                if (policy_reg == prbm_pkg::POL_LRU || policy_reg == prbm_pkg::POL_MRU)
                begin
                    for (int j = 0; j < ENTRIES; j++)
                        if ((j < int'(occ_reg)) && (rank_reg[j] < rank_reg[hit_idx]))
                            rank_next[j] = rank_reg[j] + 1'b1;
                    rank_next[hit_idx] = '0;
                end
                else if (is_clock)
                    ref_next[hit_idx] = 1'b1;
            end
            else
            begin
                if (!(&mcnt_reg))
                    mcnt_next = mcnt_reg + 1'b1;
                if (exists_q_reg && !full)
                begin
                    for (int j = 0; j < ENTRIES; j++)
                        if (j < int'(occ_reg))
                            rank_next[j] = rank_reg[j] + 1'b1;
                    tag_next[tail]  = page_q_reg;
                    dty_next[tail]  = dirty_q_reg;
                    ref_next[tail]  = is_clock;
                    rank_next[tail] = '0;
                    occ_next        = occ_reg + 1'b1;
                    r_loaded_next   = 1'b1;
                    r_slot_next     = tail;
                end
                else if (exists_q_reg)
                    victim_next = (policy_reg == prbm_pkg::POL_FIFO) ? '0 : rank_vic;
            end
        end

        if (cmd.sweep)
        begin
            if (ref_reg[hand_reg])
            begin
                ref_next[hand_reg] = 1'b0;
                hand_next = (hand_reg == last_idx) ? '0 : hand_reg + 1'b1;
            end
            else
                victim_next = hand_reg;
        end

        if (cmd.evict)
        begin
            // drop the victim, close the gap, append the new page at the tail
            for (int j = 0; j < ENTRIES - 1; j++)
            begin
                if (j < int'(victim_reg))
                begin
                    src_rank    = rank_reg[j];
                    tag_next[j] = tag_reg[j];
                    dty_next[j] = dty_reg[j];
                    ref_next[j] = ref_reg[j];
                end
                else
                begin
                    src_rank    = rank_reg[j + 1];
                    tag_next[j] = tag_reg[j + 1];
                    dty_next[j] = dty_reg[j + 1];
                    ref_next[j] = ref_reg[j + 1];
                end
                rank_next[j] = src_rank - IDX_W'(src_rank > vrank) + 1'b1;
            end
            tag_next[ENTRIES-1]  = page_q_reg;
            dty_next[ENTRIES-1]  = dirty_q_reg;
            ref_next[ENTRIES-1]  = is_clock;
            rank_next[ENTRIES-1] = '0;
            if (is_clock)
                hand_next = (victim_reg == last_idx) ? '0 : victim_reg;
            r_hit_next     = 1'b0;
            r_loaded_next  = 1'b1;
            r_slot_next    = last_idx;
            r_evicted_next = 1'b1;
            r_vpage_next   = tag_reg[victim_reg];
            r_vdirty_next  = dty_reg[victim_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= prbm_pkg::POL_LRU;
            ref_reg    <= '0;
            occ_reg    <= '0;
            hand_reg   <= '0;
            hcnt_reg   <= '0;
            mcnt_reg   <= '0;
        end
        else
        begin
            policy_reg <= policy_next;
            ref_reg    <= ref_next;
            occ_reg    <= occ_next;
            hand_reg   <= hand_next;
            hcnt_reg   <= hcnt_next;
            mcnt_reg   <= mcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_q_reg    <= page_q_next;
        exists_q_reg  <= exists_q_next;
        dirty_q_reg   <= dirty_q_next;
        tag_reg       <= tag_next;
        dty_reg       <= dty_next;
        rank_reg      <= rank_next;
        victim_reg    <= victim_next;
        r_hit_reg     <= r_hit_next;
        r_loaded_reg  <= r_loaded_next;
        r_slot_reg    <= r_slot_next;
        r_evicted_reg <= r_evicted_next;
        r_vpage_reg   <= r_vpage_next;
        r_vdirty_reg  <= r_vdirty_next;
    end

    assign st.hit        = found;
    assign st.exists     = exists_q_reg;
    assign st.full       = full;
    assign st.clock_mode = is_clock;
    assign st.hand_ref   = ref_reg[hand_reg];

    assign hit           = r_hit_reg;
    assign loaded        = r_loaded_reg;
    assign slot          = (prbm_pkg::SLOT_W)'(r_slot_reg);
    assign evicted       = r_evicted_reg;
    assign victim_page   = (prbm_pkg::PAGE_W)'(r_vpage_reg);
    assign victim_dirty  = r_vdirty_reg;
    assign hits_so_far   = hcnt_reg;
    assign misses_so_far = mcnt_reg;

endmodule

@@ design/page_replacement_buffer_manager.sv @@
// Sequence: capture on accept, then lookup; a hit, a miss not loaded or a load into a free slot
// is resolved there. An eviction under LRU, FIFO or MRU adds an evict state; under CLOCK the
// hand first sweeps past referenced slots, clearing each, before the evict state.
// A new request is taken only after the previous result is loaded; a stalled output delays lookup and eviction.
// Reset: rst_n asynchronous, active low; empties the table, clears reference bits, hand,
// counters and policy (LRU). No clearing pass.
module page_replacement_buffer_manager
#(
    parameter int ENTRIES      = 8,
    parameter int PAGE_ID_BITS = 16
)
(
    input logic         clk,
    input logic         rst_n,
    prbm_req_if.sink    req,
    prbm_rsp_if.source  rsp,
    prbm_cfg_if.sink    cfg
);

    prbm_pkg::cmd_t    cmd;
    prbm_pkg::status_t st;

    assign cfg.ready = 1'b1;

    prbm_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .st        (st),
        .cmd       (cmd)
    );

    prbm_dp #(
        .ENTRIES      (ENTRIES),
        .PAGE_ID_BITS (PAGE_ID_BITS)
    ) u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .st            (st),
        .page_id       (req.page_id),
        .page_exists   (req.page_exists),
        .dirty_mark    (req.dirty_mark),
        .cfg_write     (cfg.valid),
        .cfg_policy    (cfg.policy),
        .hit           (rsp.hit),
        .loaded        (rsp.loaded),
        .slot          (rsp.slot),
        .evicted       (rsp.evicted),
        .victim_page   (rsp.victim_page),
        .victim_dirty  (rsp.victim_dirty),
        .hits_so_far   (rsp.hits_so_far),
        .misses_so_far (rsp.misses_so_far)
    );

endmodule

@@ design/prbm_checker.sv @@
module prbm_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic                        hit,
    input logic                        loaded,
    input logic [prbm_pkg::SLOT_W-1:0] slot,
    input logic                        evicted,
    input logic [prbm_pkg::PAGE_W-1:0] victim_page,
    input logic                        victim_dirty,
    input logic [prbm_pkg::CNT_W-1:0]  hits_so_far
);

    // hold a stalled item
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(slot) && $stable(hits_so_far))
        else $error("result changed while stalled");

    a_hit_no_load: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && hit |-> !loaded && !evicted)
        else $error("hit reported a load or eviction");

    a_evict_loads: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && evicted |-> loaded)
        else $error("eviction without load");

    a_no_victim: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !evicted |-> victim_page == '0 && !victim_dirty)
        else $error("victim fields set without eviction");

    a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !hit && !loaded |-> slot == '0)
        else $error("slot set for a page not loaded");

endmodule

bind page_replacement_buffer_manager prbm_checker u_prbm_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .hit          (rsp.hit),
    .loaded       (rsp.loaded),
    .slot         (rsp.slot),
    .evicted      (rsp.evicted),
    .victim_page  (rsp.victim_page),
    .victim_dirty (rsp.victim_dirty),
    .hits_so_far  (rsp.hits_so_far)
);
